FILE: rtl/core/keyed_recency_fifo_defines.svh
// Assertion macros used by the checker of the keyed recency FIFO.
// All of them sample on i_clk and are off while i_rst_n is low.
`ifndef KEYED_RECENCY_FIFO_DEFINES_SVH
`define KEYED_RECENCY_FIFO_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KRF_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KRF_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/krf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krf_pkg;

    // Buffer depth and derived widths
    localparam int DEPTH     = 32;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OCC_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ID_MODE  = 1'd1;

    // Register reset values
    localparam logic [7:0] CAPACITY_RST = 8'd32;
    localparam logic       ID_MODE_RST  = 1'b1;

    typedef enum logic [1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_PEEK    = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       command;
        logic [7:0] rec_id;
        logic [7:0] rec_state;
        logic [7:0] rec_hops;
    } t_in_word;

    typedef struct packed {
        logic             ok;
        logic [7:0]       item_id;
        logic [7:0]       item_state;
        logic [7:0]       item_hops;
        logic [OCC_W-1:0] occupancy;
    } t_out_word;

    // One stored record
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] st;
        logic [7:0] hops;
    } t_entry;

    // Pointer + 1 modulo DEPTH
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (int'(p) == DEPTH - 1) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // a + b modulo DEPTH, both operands below DEPTH
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                 input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (int'(s) >= DEPTH) begin
            s = s - (PTR_W+1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/keyed_recency_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Keyed recency FIFO: a circular buffer of DEPTH records (id, state, hops) held in one
// single-port-read, single-port-write RAM with a registered read. One word is worked on
// at a time; o_in_ready is high only while the engine is idle, and a finished result
// waits in the output register until taken. A keyed update walks the entries left
// after trimming from the head, reading each entry and then comparing it, and on a hit
// shifts every younger entry down one slot, reading each and then writing it back. A
// result that is not taken holds the engine until the output register frees up.
// Configuration writes are taken at any time but must only be issued while the block
// is idle; a capacity above DEPTH acts as DEPTH.
module keyed_recency_fifo
    import krf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // command in
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,
    // result out
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPEND,
        S_DONE
    } t_state_e;

    t_state_e          r_state;
    logic [7:0]        r_cap;
    logic              r_id_mode;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [PTR_W-1:0]  r_rp;
    t_in_word          r_word;
    logic              r_ok;
    t_entry            r_pk;
    logic              r_out_valid;
    t_out_word         r_out;

    t_entry            mem [DEPTH];
    t_entry            r_rdata;

    logic              mem_re;
    logic [PTR_W-1:0]  mem_raddr;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;
    t_entry            mem_wdata;

    logic [CNT_W-1:0]  cap_eff;
    logic              trim;
    logic [PTR_W-1:0]  trim_head;
    logic [CNT_W-1:0]  trim_count;
    logic [CNT_W-1:0]  end_idx;
    logic              full;
    logic              in_acc;
    logic              out_free;
    t_entry            new_rec;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAPACITY_RST;
            r_id_mode <= ID_MODE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_CAPACITY: r_cap     <= i_cfg_data;
                REG_ID_MODE:  r_id_mode <= i_cfg_data[0];
            endcase
        end
    end

    // Effective capacity and trimming of excess entries
    always_comb begin
        if (int'(r_cap) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(r_cap);
        end
        trim       = (r_count > cap_eff);
        trim_head  = trim ? ptr_add(r_head, PTR_W'(r_count - cap_eff)) : r_head;
        trim_count = trim ? cap_eff : r_count;
        end_idx    = r_count - CNT_W'(1);
        full       = (r_count >= cap_eff);
        new_rec.id   = r_id_mode ? r_word.rec_id : 8'd0;
        new_rec.st   = r_word.rec_state;
        new_rec.hops = r_word.rec_hops;
    end

    // RAM port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_rp;
        mem_we    = 1'b0;
        mem_waddr = r_rp;
        mem_wdata = new_rec;
        case (r_state)
            S_EXEC: begin
                mem_re    = 1'b1;
                mem_raddr = r_head;
            end
            S_SRCH_RD: begin
                mem_re = 1'b1;
            end
            S_SHIFT_RD: begin
                if (r_idx == end_idx) begin
                    mem_we = 1'b1;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_inc(r_rp);
                end
            end
            S_SHIFT_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
            end
            S_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = r_tail;
            end
            default: begin
            end
        endcase
    end

    // Entry RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // Command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result taken; a new one loaded in S_DONE takes its place
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_word  <= i_in_word;
                        r_ok    <= 1'b1;
                        r_pk    <= '0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_word.command)
                        CMD_UPDATE: begin
                            if (cap_eff == '0) begin
                                r_head  <= '0;
                                r_tail  <= '0;
                                r_count <= '0;
                                r_state <= S_DONE;
                            end else begin
                                r_head  <= trim_head;
                                r_count <= trim_count;
                                r_rp    <= trim_head;
                                r_idx   <= '0;
                                r_state <= r_id_mode ? S_SRCH_RD : S_APPEND;
                            end
                        end
                        CMD_PEEK: begin
                            if (r_count == '0) begin
                                r_ok    <= 1'b0;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_PEEK;
                            end
                        end
                        CMD_DEQUEUE: begin
                            if (r_count == '0) begin
                                r_ok <= 1'b0;
                            end else begin
                                r_head  <= ptr_inc(r_head);
                                r_count <= r_count - CNT_W'(1);
                            end
                            r_state <= S_DONE;
                        end
                        CMD_CLEAR: begin
                            r_head  <= '0;
                            r_tail  <= '0;
                            r_count <= '0;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_PEEK: begin
                    r_pk    <= r_rdata;
                    r_state <= S_DONE;
                end
                // key search: read one entry, compare it next cycle
                S_SRCH_RD: begin
                    if (r_idx == r_count) begin
                        r_state <= S_APPEND;
                    end else begin
                        r_state <= S_SRCH_CMP;
                    end
                end
                S_SRCH_CMP: begin
                    if (r_rdata.id == r_word.rec_id) begin
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_idx   <= r_idx + CNT_W'(1);
                        r_rp    <= ptr_inc(r_rp);
                        r_state <= S_SRCH_RD;
                    end
                end
                // move younger entries down one slot, new record lands at the tail end
                S_SHIFT_RD: begin
                    if (r_idx == end_idx) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_SHIFT_WR;
                    end
                end
                S_SHIFT_WR: begin
                    r_idx   <= r_idx + CNT_W'(1);
                    r_rp    <= ptr_inc(r_rp);
                    r_state <= S_SHIFT_RD;
                end
                // append at tail, evicting the head when full
                S_APPEND: begin
                    r_tail <= ptr_inc(r_tail);
                    if (full) begin
                        r_head <= ptr_inc(r_head);
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.ok         <= r_ok;
                        r_out.item_id    <= r_pk.id;
                        r_out.item_state <= r_pk.st;
                        r_out.item_hops  <= r_pk.hops;
                        r_out.occupancy  <= OCC_W'(r_count);
                        r_out_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/krf_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "keyed_recency_fifo_defines.svh"

// Port-level checks for the keyed recency FIFO
module krf_chk
    import krf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 o_in_ready,
    input  wire logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire t_out_word            o_out_word
);

    // a stalled result holds
    `KRF_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word), "result dropped or changed while stalled")

    // one word at a time: input closes right after an accept
    `KRF_NEXT(a_single_item, i_in_valid && o_in_ready, !o_in_ready, "second word accepted while busy")

    // a failed peek or dequeue carries no item and reports zero occupancy
    `KRF_IMPLIES(a_fail_empty, o_out_valid && !o_out_word.ok, (o_out_word.item_id == 8'd0) && (o_out_word.item_state == 8'd0) && (o_out_word.item_hops == 8'd0) && (o_out_word.occupancy == '0), "failed result with item data or nonzero occupancy")

    // occupancy never exceeds the buffer depth
    `KRF_IMPLIES(a_occ_bound, o_out_valid, int'(o_out_word.occupancy) <= DEPTH, "occupancy above depth")

endmodule

bind keyed_recency_fifo krf_chk u_krf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

`default_nettype wire

FILE: verif/keyed_recency_fifo_tb.sv
`timescale 1ns / 1ps

module keyed_recency_fifo_tb;
    import krf_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 2 * DEPTH + 8;
    localparam int RAND_PHASES     = 12;
    localparam int WORDS_PER_PHASE = 150;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    t_in_word             in_word   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_ready;
    logic                 in_ready;
    logic                 out_valid;
    t_out_word            out_word;

    // Shadow copy of the buffer and its registers
    t_entry     shadow_store [DEPTH];
    int         shadow_head  = 0;
    int         shadow_tail  = 0;
    int         shadow_count = 0;
    int         shadow_cap   = int'(CAPACITY_RST);
    logic       shadow_keyed = ID_MODE_RST;

    t_in_word   cmd_backlog [$];
    t_out_word  resp_due [$];
    int         words_queued   = 0;
    int         words_taken    = 0;
    int         fail_count     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    logic       hold_go        = 1'b0;
    logic       hold_on        = 1'b0;
    logic [7:0] id_pool [64];

    keyed_recency_fifo u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow buffer primitives
    function automatic void drop_oldest();
        shadow_head  = (shadow_head + 1) % DEPTH;
        shadow_count = shadow_count - 1;
    endfunction

    function automatic void push_entry(input logic [7:0] id, input logic [7:0] st,
                                       input logic [7:0] hops);
        shadow_store[shadow_tail] = '{id, st, hops};
        shadow_tail  = (shadow_tail + 1) % DEPTH;
        shadow_count = shadow_count + 1;
    endfunction

    // Applies one command word to the shadow buffer and returns its response
    function automatic t_out_word predict_response(input t_in_word w);
        t_out_word r;
        int        lim;
        int        hit;
        int        last;
        int        i;
        r    = '0;
        r.ok = 1'b1;
        hit  = -1;
        case (w.command)
            CMD_UPDATE: begin
                lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
                if (lim == 0) begin
                    // zero capacity empties the buffer
                    shadow_head  = 0;
                    shadow_tail  = 0;
                    shadow_count = 0;
                end else begin
                    while (shadow_count > lim) drop_oldest();
                    if (!shadow_keyed) begin
                        if (shadow_count >= lim) drop_oldest();
                        push_entry(8'd0, w.rec_state, w.rec_hops);
                    end else begin
                        for (i = 0; i < shadow_count && hit < 0; i++) begin
                            if (shadow_store[(shadow_head + i) % DEPTH].id == w.rec_id) hit = i;
                        end
                        if (hit < 0) begin
                            if (shadow_count >= lim) drop_oldest();
                            push_entry(w.rec_id, w.rec_state, w.rec_hops);
                        end else begin
                            // close the gap, then rewrite the record at the tail
                            last = shadow_count - 1;
                            for (i = hit; i < last; i++) begin
                                shadow_store[(shadow_head + i) % DEPTH] =
                                    shadow_store[(shadow_head + i + 1) % DEPTH];
                            end
                            shadow_store[(shadow_head + last) % DEPTH] =
                                '{w.rec_id, w.rec_state, w.rec_hops};
                        end
                    end
                end
            end
            CMD_PEEK: begin
                if (shadow_count == 0) begin
                    r.ok = 1'b0;
                end else begin
                    r.item_id    = shadow_store[shadow_head].id;
                    r.item_state = shadow_store[shadow_head].st;
                    r.item_hops  = shadow_store[shadow_head].hops;
                end
            end
            CMD_DEQUEUE: begin
                if (shadow_count == 0) begin
                    r.ok = 1'b0;
                end else begin
                    drop_oldest();
                end
            end
            CMD_CLEAR: begin
                shadow_head  = 0;
                shadow_tail  = 0;
                shadow_count = 0;
            end
        endcase
        r.occupancy = OCC_W'(shadow_count);
        return r;
    endfunction

    // Random command: mostly updates on a small id pool so keys hit
    function automatic t_in_word random_word(input int pool_n);
        t_in_word w;
        int       pick;
        pick = $urandom_range(99, 0);
        if (pick < 58) begin
            w.command = CMD_UPDATE;
        end else if (pick < 78) begin
            w.command = CMD_PEEK;
        end else if (pick < 97) begin
            w.command = CMD_DEQUEUE;
        end else begin
            w.command = CMD_CLEAR;
        end
        if ($urandom_range(99, 0) < 75) begin
            w.rec_id = id_pool[$urandom_range(pool_n - 1, 0)];
        end else begin
            w.rec_id = 8'($urandom);
        end
        w.rec_state = 8'($urandom);
        w.rec_hops  = 8'($urandom);
        return w;
    endfunction

    task automatic queue_word(input t_in_word w);
        cmd_backlog.push_back(w);
        words_queued++;
    endtask

    task automatic queue_cmd(input t_cmd c, input logic [7:0] id, input logic [7:0] st,
                             input logic [7:0] hops);
        t_in_word w;
        w = '{c, id, st, hops};
        queue_word(w);
    endtask

    // Register write; shadow follows once the handshake completes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CAPACITY) begin
            shadow_cap = int'(val);
        end else begin
            shadow_keyed = val[0];
        end
    endtask

    // Wait until every queued word is taken and answered, then let the engine settle
    task automatic wait_idle();
        while (words_taken != words_queued || resp_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                resp_due.push_back(predict_response(in_word));
                words_taken++;
            end
            if (!in_valid || in_ready) begin
                if (cmd_backlog.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    in_word  <= cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor and checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (resp_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %p", $time, out_word);
                    fail_count++;
                end else begin
                    want = resp_due.pop_front();
                    if (out_word.ok !== want.ok || out_word.item_id !== want.item_id ||
                        out_word.item_state !== want.item_state ||
                        out_word.item_hops !== want.item_hops ||
                        out_word.occupancy !== want.occupancy) begin
                        $display("%0t: result mismatch, expected %p, got %p",
                                 $time, want, out_word);
                        fail_count++;
                    end
                end
            end
            out_ready <= !hold_on && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the block backs up
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int         ph;
        int         k;
        int         pool_n;
        logic [7:0] cap;
        logic       keyed;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty reads, extremes, tail hit, head hit, clear
        queue_cmd(CMD_PEEK,    8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_DEQUEUE, 8'hFF, 8'hFF, 8'hFF);
        queue_cmd(CMD_UPDATE,  8'hFF, 8'h00, 8'hFF);
        queue_cmd(CMD_UPDATE,  8'h00, 8'hFF, 8'h00);
        queue_cmd(CMD_UPDATE,  8'h5A, 8'hA5, 8'h3C);
        queue_cmd(CMD_UPDATE,  8'h5A, 8'h11, 8'h22);
        queue_cmd(CMD_UPDATE,  8'hFF, 8'h33, 8'h44);
        queue_cmd(CMD_PEEK,    8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_DEQUEUE, 8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_PEEK,    8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_CLEAR,   8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_PEEK,    8'h00, 8'h00, 8'h00);
        wait_idle();

        // Tiny capacity: eviction on miss, then a tail hit while full
        write_reg(REG_CAPACITY, 8'd2);
        queue_cmd(CMD_UPDATE, 8'h10, 8'h01, 8'h02);
        queue_cmd(CMD_UPDATE, 8'h20, 8'h03, 8'h04);
        queue_cmd(CMD_UPDATE, 8'h30, 8'h05, 8'h06);
        queue_cmd(CMD_PEEK,   8'h00, 8'h00, 8'h00);
        queue_cmd(CMD_UPDATE, 8'h30, 8'h07, 8'h08);
        wait_idle();

        // Zero capacity wipes on update
        write_reg(REG_CAPACITY, 8'd0);
        queue_cmd(CMD_UPDATE, 8'h77, 8'h88, 8'h99);
        queue_cmd(CMD_PEEK,   8'h00, 8'h00, 8'h00);
        wait_idle();

        // Plain append with saturated capacity: id stored as zero
        write_reg(REG_ID_MODE, CFG_DAT_W'(1'b0));
        write_reg(REG_CAPACITY, 8'd255);
        queue_cmd(CMD_UPDATE, 8'hAB, 8'hCD, 8'hEF);
        queue_cmd(CMD_PEEK,   8'h00, 8'h00, 8'h00);
        wait_idle();

        // Random phases over several settings and pacing mixes
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0:       begin cap = 8'd32;         keyed = 1'b1;        end
                1:       begin cap = 8'd255;        keyed = 1'b1;        end
                2:       begin cap = 8'd33;         keyed = 1'b0;        end
                3:       begin cap = 8'd1;          keyed = 1'b1;        end
                4:       begin cap = 8'd0;          keyed = 1'b1;        end
                5:       begin cap = 8'd2;          keyed = 1'b0;        end
                6:       begin cap = 8'd31;         keyed = 1'b1;        end
                7:       begin cap = 8'($urandom);  keyed = 1'b1;        end
                8:       begin cap = 8'd3;          keyed = 1'b1;        end
                9:       begin cap = 8'd255;        keyed = 1'b0;        end
                10:      begin cap = 8'd5;          keyed = 1'b1;        end
                default: begin cap = 8'($urandom);  keyed = 1'($urandom); end
            endcase
            write_reg(REG_CAPACITY, cap);
            write_reg(REG_ID_MODE, CFG_DAT_W'(keyed));
            case (ph % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            pool_n = $urandom_range(40, 3);
            for (k = 0; k < pool_n; k++) id_pool[k] = 8'($urandom);
            for (k = 0; k < WORDS_PER_PHASE; k++) queue_word(random_word(pool_n));
            if (ph == 0) hold_go = 1'b1;
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
